@@ hw/rtl/mfd_pkg.sv @@
// shared constants, types and the sine polynomial of the modulated feedback delay
`default_nettype none

package mfd_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_DELAY_LENGTH  = 3'd0,
        CFG_FEEDBACK_GAIN = 3'd1,
        CFG_WET_MIX       = 3'd2,
        CFG_WOW_DEPTH     = 3'd3,
        CFG_PHASE_STEP    = 3'd4
    } mfd_cfg_t;

    // ring read/write strobes from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mfd_ring_ctl_t;

    localparam int DELAY_INT_BITS = 17;     // integer part of the Q8 delay
    localparam int SINE_Q_BITS    = 17;     // quadrant (2) + angle (15)

    localparam logic [16:0] UNITY_Q16   = 17'd65536;
    localparam logic [10:0] WOW_SCALE   = 11'd1311;   // 0.02 in Q16
    localparam logic [15:0] DELAY_RESET = 16'd12000;
    localparam logic [16:0] MIX_RESET   = 17'd32768;

    // half lsb for the 2^-39 rounding of the wow offset
    localparam logic signed [59:0] OFF_HALF = 60'sd274877906944;

    localparam logic [63:0] SIN_A = 64'd51472;
    localparam logic [63:0] SIN_B = 64'd21024;
    localparam logic [63:0] SIN_C = 64'd2320;

    // Q15 sine of a quarter-wave angle code, -32768..32768
    function automatic logic signed [16:0] sine_q15(input logic [SINE_Q_BITS-1:0] q);
        logic [1:0]  quad;
        logic [63:0] f;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] t;
        logic [63:0] s;
        logic [16:0] mag;
        quad = q[16:15];
        f    = {49'd0, q[14:0]};
        z    = quad[0] ? (64'd32768 - f) : f;
        z2   = (z * z) >> 15;
        t    = SIN_B - ((SIN_C * z2) >> 15);
        t    = SIN_A - ((t * z2) >> 15);
        s    = (t * z) >> 15;
        mag  = s[16:0];
        return quad[1] ? $signed(-mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mfd_ring.sv @@
// delay ring: one write port, two registered read ports, fill tracking instead of a clear
`default_nettype none

module mfd_ring import mfd_pkg::*; #(
    parameter int RING_DEPTH  = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire mfd_ring_ctl_t                 ctl,
    input  wire logic [DELAY_INT_BITS-1:0]     rd_delay,
    input  wire logic signed [SAMPLE_BITS-1:0] wr_data,
    output logic signed [SAMPLE_BITS-1:0]      rd_data0,
    output logic signed [SAMPLE_BITS-1:0]      rd_data1
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int XW = (AW > DELAY_INT_BITS) ? AW : DELAY_INT_BITS;

    logic signed [SAMPLE_BITS-1:0] mem [RING_DEPTH];

    logic [AW-1:0] wp_reg, wp_next;
    logic          wrapped_reg, wrapped_next;
    logic          valid0_reg, valid1_reg;
    logic signed [SAMPLE_BITS-1:0] q0_reg, q1_reg;

    logic [XW-1:0] diff;
    logic [AW-1:0] addr0, addr1;

    // ring index arithmetic wraps at the power-of-two depth
    assign diff  = XW'(wp_reg) - XW'(rd_delay);
    assign addr0 = diff[AW-1:0];
    assign addr1 = addr0 - AW'(1);

    always_comb begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (ctl.wr_en) begin
            wp_next = wp_reg + AW'(1);
            if (wp_reg == AW'(RING_DEPTH - 1)) begin
                wrapped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            valid0_reg  <= 1'b0;
            valid1_reg  <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
            if (ctl.rd_en) begin
                // entries not yet written since reset read as zero
                valid0_reg <= wrapped_reg || (addr0 < wp_reg);
                valid1_reg <= wrapped_reg || (addr1 < wp_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wp_reg] <= wr_data;
        end
        if (ctl.rd_en) begin
            q0_reg <= mem[addr0];
            q1_reg <= mem[addr1];
        end
    end

    assign rd_data0 = valid0_reg ? q0_reg : '0;
    assign rd_data1 = valid1_reg ? q1_reg : '0;

endmodule

`default_nettype wire

@@ hw/rtl/modulated_feedback_delay_top.sv @@
// top level of the modulated feedback delay: config registers, sequencer and datapath
`default_nettype none

// Modulated feedback delay line. Each input beat is one signed sample; each output
// beat is the saturated dry/wet mix. The delay is delay_length plus a sine wow offset
// (wow_depth * sine * 0.02 * delay_length) held with 8 fraction bits, and the two ring
// entries around it are linearly interpolated. A sample is taken only while the sequencer
// is idle, and the sequencer returns to idle once the result is produced; in between it
// walks through the sine lookup, two wow multiply stages, the ring read, interpolation
// and the feedback/mix multiplies. The result sits in an output register, so a new
// sample is accepted while it waits; that sample holds in its last step until the
// previous result has been taken. RING_DEPTH and SINE_TABLE_DEPTH must be powers of
// two. The ring needs no clearing pass after reset: entries not yet written read as
// zero, tracked from the write pointer. Configuration must be written while idle;
// the block itself does not enforce this.
module modulated_feedback_delay_top import mfd_pkg::*; #(
    parameter int RING_DEPTH       = 65536,
    parameter int SAMPLE_BITS      = 24,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_addr,
    input  wire logic [31:0]                   cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_in_sample,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_out_sample
);

    localparam int SB      = SAMPLE_BITS;
    localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);
    localparam int LW      = SB + 11;   // interpolation sum
    localparam int FW      = SB + 17;   // feedback product
    localparam int MW      = SB + 19;   // mix sum

    typedef logic signed [16:0] sine_rom_t [SINE_TABLE_DEPTH];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            rom[k] = sine_q15(SINE_Q_BITS'(k << (SINE_Q_BITS - SINE_AW)));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // clamp a wide signed value to the sample range
    function automatic logic signed [SB-1:0] sat_sample(input logic signed [SB+2:0] v);
        logic [3:0] top;
        top = v[SB+2:SB-1];
        if (top == 4'b0000 || top == 4'b1111) begin
            return v[SB-1:0];
        end else if (v[SB+2]) begin
            return {1'b1, {(SB-1){1'b0}}};
        end else begin
            return {1'b0, {(SB-1){1'b1}}};
        end
    endfunction

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL1 = 8'b0000_0010,
        S_MUL2 = 8'b0000_0100,
        S_ADDR = 8'b0000_1000,
        S_LERP = 8'b0001_0000,
        S_FB   = 8'b0010_0000,
        S_MIX  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    // configuration
    logic [15:0] delay_length_reg;
    logic [15:0] feedback_gain_reg;
    logic [16:0] wet_mix_reg;
    logic [16:0] wow_depth_reg;
    logic [31:0] phase_step_reg;

    // control
    state_t      state_reg, state_next;
    logic [31:0] lfo_phase_reg, lfo_phase_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;
    logic        in_beat;
    mfd_ring_ctl_t ring_ctl;

    // payload
    logic signed [SB-1:0] x_reg;
    logic signed [16:0]   sin_reg;
    logic signed [32:0]   p1_reg;
    logic [26:0]          p2_reg;
    logic signed [59:0]   prod_reg;
    logic [7:0]           frac_reg;
    logic signed [SB+9:0] la_reg, lb_reg;
    logic signed [SB-1:0] delayed_reg;
    logic signed [FW-1:0] fbp_reg;
    logic signed [SB+17:0] mxa_reg, mxb_reg;
    logic signed [SB-1:0] out_reg;

    // datapath wires
    logic [16:0]          depth_c, mix_c;
    logic signed [34:0]   p1_full;
    logic signed [60:0]   prod_full;
    logic signed [59:0]   off_sum;
    logic signed [20:0]   offset;
    logic signed [25:0]   dq8;
    logic [24:0]          dq8_clamped;
    logic [DELAY_INT_BITS-1:0] delay_int;
    logic signed [SB-1:0] s0, s1;
    logic signed [LW-1:0] lerp_sum;
    logic signed [FW-1:0] fb_sum;
    logic signed [SB:0]   fb_term;
    logic signed [SB+2:0] stored_w;
    logic signed [MW-1:0] mix_sum;
    logic signed [SB+2:0] mixed_w;
    logic signed [SB-1:0] stored, mixed;

    assign depth_c = (wow_depth_reg > UNITY_Q16) ? UNITY_Q16 : wow_depth_reg;
    assign mix_c   = (wet_mix_reg > UNITY_Q16) ? UNITY_Q16 : wet_mix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_length_reg  <= DELAY_RESET;
            feedback_gain_reg <= '0;
            wet_mix_reg       <= MIX_RESET;
            wow_depth_reg     <= '0;
            phase_step_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DELAY_LENGTH:  delay_length_reg  <= cfg_wdata[15:0];
                CFG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_wdata[15:0];
                CFG_WET_MIX:       wet_mix_reg       <= cfg_wdata[16:0];
                CFG_WOW_DEPTH:     wow_depth_reg     <= cfg_wdata[16:0];
                CFG_PHASE_STEP:    phase_step_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        lfo_phase_next = lfo_phase_reg;
        out_valid_next = out_valid_reg;
        ring_ctl       = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    lfo_phase_next = lfo_phase_reg + phase_step_reg;
                    state_next     = S_MUL1;
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_ADDR;
            S_ADDR: begin
                ring_ctl.rd_en = 1'b1;
                state_next     = S_LERP;
            end
            S_LERP: state_next = S_FB;
            S_FB:   state_next = S_MIX;
            S_MIX:  state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    ring_ctl.wr_en = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            lfo_phase_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lfo_phase_reg <= lfo_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // wow offset: depth * sine, then * (length * 0.02), rounded to Q8 samples
    assign p1_full   = $signed({1'b0, depth_c}) * sin_reg;
    assign prod_full = p1_reg * $signed({1'b0, p2_reg});
    assign off_sum   = prod_reg + OFF_HALF;
    assign offset    = off_sum[59:39];
    assign dq8       = $signed({2'b00, delay_length_reg, 8'd0}) + 26'(offset);
    assign dq8_clamped = dq8[25] ? '0 : dq8[24:0];
    assign delay_int = dq8_clamped[24:8];

    mfd_ring #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ring_ctl),
        .rd_delay (delay_int),
        .wr_data  (stored),
        .rd_data0 (s0),
        .rd_data1 (s1)
    );

    assign lerp_sum = LW'(la_reg) + LW'(lb_reg) + LW'(128);
    assign fb_sum   = fbp_reg + FW'(32768);
    assign fb_term  = fb_sum[FW-1:16];
    assign stored_w = (SB+3)'(x_reg) + (SB+3)'(fb_term);
    assign mix_sum  = MW'(mxa_reg) + MW'(mxb_reg) + MW'(32768);
    assign mixed_w  = mix_sum[MW-1:16];
    assign stored   = sat_sample(stored_w);
    assign mixed    = sat_sample(mixed_w);

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    x_reg   <= s_in_sample;
                    sin_reg <= SINE_ROM[lfo_phase_reg[31 -: SINE_AW]];
                end
            end
            S_MUL1: begin
                p1_reg <= p1_full[32:0];
                p2_reg <= {11'd0, delay_length_reg} * {16'd0, WOW_SCALE};
            end
            S_MUL2: prod_reg <= prod_full[59:0];
            S_ADDR: frac_reg <= dq8_clamped[7:0];
            S_LERP: begin
                la_reg <= s0 * $signed({1'b0, 9'd256 - {1'b0, frac_reg}});
                lb_reg <= s1 * $signed({2'b00, frac_reg});
            end
            S_FB: delayed_reg <= lerp_sum[SB+7:8];
            S_MIX: begin
                fbp_reg <= delayed_reg * $signed({1'b0, feedback_gain_reg});
                mxa_reg <= x_reg * $signed({1'b0, UNITY_Q16 - mix_c});
                mxb_reg <= delayed_reg * $signed({1'b0, mix_c});
            end
            S_OUT: begin
                if (out_free) begin
                    out_reg <= mixed;
                end
            end
            default: ;
        endcase
    end

    assign m_valid      = out_valid_reg;
    assign m_out_sample = out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mfd_checker.sv @@
// port-level checks of the modulated feedback delay, bound to the top level
`default_nettype none

module mfd_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [SAMPLE_BITS-1:0] m_out_sample
);

    // samples taken but not yet delivered
    logic [1:0] pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(s_valid && s_ready) - 2'(m_valid && m_ready);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_sample))
        else $error("output beat dropped or changed while stalled");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("output beat without a matching input beat");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 2'd2 |-> !s_ready)
        else $error("input taken with a sample in work and a result waiting");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second input beat taken while a sample is in work");

endmodule

bind modulated_feedback_delay_top mfd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mfd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_sample (m_out_sample)
);

`default_nettype wire
